/* rtl/core/stereo_peak_true_peak_rms_meter_defines.svh */
// Assertion macros shared by the meter RTL.
`ifndef STEREO_PEAK_TRUE_PEAK_RMS_METER_DEFINES_SVH
`define STEREO_PEAK_TRUE_PEAK_RMS_METER_DEFINES_SVH

// The condition must hold whenever the trigger holds in the same cycle.
`define SPM_ASSERT_NOW(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("meter assertion failed");

// The condition must hold in the cycle after the trigger.
`define SPM_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("meter assertion failed");

`endif

/* rtl/core/spm_pkg.sv */
// Types, constants and interpolation weights for the stereo meter.
`default_nettype none
package spm_pkg;
   localparam int SAMPLE_W = 24;
   localparam int SUM_BITS = 63;
   localparam int ACC_W    = 32;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ROOT} top_state_type;
   typedef enum logic [1:0] {ROOT_IDLE, ROOT_DIV, ROOT_SQRT, ROOT_DONE} root_state_type;

   typedef struct packed {
      logic       active;
      logic [1:0] step;
      logic       count_it;
      logic       fill_full;
      logic       clear;
   } lane_ctrl_type;

   // Lagrange weights in 1/128 units for phases 1/4, 1/2 and 3/4.
   function automatic logic signed [7:0] interp_weight(input logic [1:0] phase,
                                                       input logic [1:0] tap);
      logic signed [7:0] w;
      w = 8'sd0;
      case ({phase, tap})
         4'h0: w = -8'sd7;
         4'h1: w = 8'sd105;
         4'h2: w = 8'sd35;
         4'h3: w = -8'sd5;
         4'h4: w = -8'sd8;
         4'h5: w = 8'sd72;
         4'h6: w = 8'sd72;
         4'h7: w = -8'sd8;
         4'h8: w = -8'sd5;
         4'h9: w = 8'sd35;
         4'hA: w = 8'sd105;
         4'hB: w = -8'sd7;
         default: w = 8'sd0;
      endcase
      return w;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/stereo_peak_true_peak_rms_meter.sv */
// Stereo sample-peak, true-peak and RMS meter: control, two lanes and the result stage.
// Input channel req_*: one stereo frame per item, signed Q1.23, with req_last_frame
// closing a metering block. Result channel rsp_*: one item per block, sent after the
// frame marked last. csr_wr_en/csr_wr_data write the mono flag; the user must write it
// only while the block is idle; the block itself has no check for this. Each frame
// goes through the accept cycle and four work steps in both lanes (sample peak and
// square, then one interpolation phase per step on the shared weighted-sum path). A
// last frame then runs each lane's divider and square root. The output register holds a
// result until it is taken; frames keep being accepted meanwhile, and the next block
// end waits only if that register is still full. Reset clears history, statistics and
// the mono flag; no result is pending after reset.
`default_nettype none
`include "stereo_peak_true_peak_rms_meter_defines.svh"
module stereo_peak_true_peak_rms_meter #(
   parameter int MAX_FRAMES  = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [spm_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [spm_pkg::SAMPLE_W-1:0] req_right_sample,
   input  logic                                req_last_frame,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_peak_left,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_peak_right,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_true_peak_left,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_true_peak_right,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_rms_left,
   output logic [spm_pkg::SAMPLE_W-1:0]        rsp_rms_right,
   output logic                                rsp_block_overflow,
   input  logic                                csr_wr_en,
   input  logic                                csr_wr_data
);
   import spm_pkg::*;

   localparam int FB = $clog2(MAX_FRAMES + 1);
   localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

   top_state_type       state_ff, state_in;
   logic [1:0]          step_ff, step_in;
   logic [FB-1:0]       frames_ff, frames_in;
   logic                ovf_ff, ovf_in;
   logic [1:0]          fill_ff, fill_in;
   logic                mono_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic                last_ff, count_ff, full_ff;
   logic [SAMPLE_W-1:0] o_pl_ff, o_pr_ff, o_tl_ff, o_tr_ff, o_rl_ff, o_rr_ff;
   logic                o_ovf_ff;
   logic signed [SAMPLE_W-1:0] l_sh, r_sh, l_sx, r_sx;
   logic                accept, count_now, root_start, load_out;
   lane_ctrl_type       lctrl;
   logic [SAMPLE_W-1:0] pk_l, pk_r, tp_l, tp_r, rms_l, rms_r;
   logic [SUM_BITS-1:0] sum_l, sum_r;
   logic                done_l, done_r;
   logic [FB-1:0]       denom;

   assign l_sh = req_left_sample << SHIFT;
   assign r_sh = req_right_sample << SHIFT;
   assign l_sx = l_sh >>> SHIFT;
   assign r_sx = r_sh >>> SHIFT;
   assign accept = req_valid && req_ready;
   assign count_now = frames_ff < FB'(MAX_FRAMES);
   assign denom = (frames_ff == '0) ? FB'(1) : frames_ff;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      frames_in = frames_ff;
      ovf_in = ovf_ff;
      fill_in = fill_ff;
      root_start = 1'b0;
      load_out = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_RUN;
               step_in = 2'd0;
               if (count_now) frames_in = frames_ff + FB'(1);
               else ovf_in = 1'b1;
               if (fill_ff != 2'd3) fill_in = fill_ff + 2'd1;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               if (last_ff) begin
                  root_start = 1'b1;
                  state_in = ST_ROOT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ROOT: begin
            if (done_l && done_r && (!rsp_valid_ff || rsp_ready)) begin
               load_out = 1'b1;
               frames_in = '0;
               ovf_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      lctrl.active = (state_ff == ST_RUN);
      lctrl.step = step_ff;
      lctrl.count_it = count_ff;
      lctrl.fill_full = full_ff;
      lctrl.clear = load_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         frames_ff <= '0;
         ovf_ff <= 1'b0;
         fill_ff <= '0;
         mono_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         frames_ff <= frames_in;
         ovf_ff <= ovf_in;
         fill_ff <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) mono_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         left_ff <= l_sx;
         right_ff <= mono_ff ? l_sx : r_sx;
         last_ff <= req_last_frame;
         count_ff <= count_now;
         full_ff <= (fill_ff == 2'd3);
      end
      if (load_out) begin
         o_pl_ff <= pk_l;
         o_pr_ff <= pk_r;
         o_tl_ff <= tp_l;
         o_tr_ff <= tp_r;
         o_rl_ff <= rms_l;
         o_rr_ff <= rms_r;
         o_ovf_ff <= ovf_ff;
      end
   end

   spm_lane u_lane_left (
      .clock(clock), .reset(reset), .ctrl(lctrl), .sample(left_ff),
      .peak(pk_l), .true_peak(tp_l), .square_sum(sum_l)
   );

   spm_lane u_lane_right (
      .clock(clock), .reset(reset), .ctrl(lctrl), .sample(right_ff),
      .peak(pk_r), .true_peak(tp_r), .square_sum(sum_r)
   );

   spm_root #(.FRAME_BITS(FB)) u_root_left (
      .clock(clock), .reset(reset), .start(root_start), .numer(sum_l),
      .denom(denom), .done(done_l), .root(rms_l)
   );

   spm_root #(.FRAME_BITS(FB)) u_root_right (
      .clock(clock), .reset(reset), .start(root_start), .numer(sum_r),
      .denom(denom), .done(done_r), .root(rms_r)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_peak_left = o_pl_ff;
   assign rsp_peak_right = o_pr_ff;
   assign rsp_true_peak_left = o_tl_ff;
   assign rsp_true_peak_right = o_tr_ff;
   assign rsp_rms_left = o_rl_ff;
   assign rsp_rms_right = o_rr_ff;
   assign rsp_block_overflow = o_ovf_ff;

   `SPM_ASSERT_NOW(a_frames_bound, clock, reset, 1'b1, frames_ff <= FB'(MAX_FRAMES))
   `SPM_ASSERT_NOW(a_ovf_saturated, clock, reset, ovf_ff, frames_ff == FB'(MAX_FRAMES))
   `SPM_ASSERT_NEXT(a_last_roots, clock, reset, state_ff == ST_RUN && step_ff == 2'd3 && last_ff, state_ff == ST_ROOT && !done_l && !done_r)
endmodule
`default_nettype wire

/* rtl/core/spm_lane.sv */
// One channel: sample peak, interpolated true peak, sum of squares and history.
`default_nettype none
module spm_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  spm_pkg::lane_ctrl_type              ctrl,
   input  logic signed [spm_pkg::SAMPLE_W-1:0] sample,
   output logic [spm_pkg::SAMPLE_W-1:0]        peak,
   output logic [spm_pkg::SAMPLE_W-1:0]        true_peak,
   output logic [spm_pkg::SUM_BITS-1:0]        square_sum
);
   import spm_pkg::*;

   logic [SAMPLE_W-1:0]        peak_ff, peak_in;
   logic [SAMPLE_W-1:0]        tpeak_ff, tpeak_in;
   logic [SUM_BITS-1:0]        sum_ff, sum_in;
   logic [2*SAMPLE_W-1:0]      prod_ff;
   logic signed [SAMPLE_W-1:0] hist_ff [3];
   logic signed [SAMPLE_W-1:0] taps [4];
   logic signed [ACC_W-1:0]    acc;
   logic signed [SAMPLE_W:0]   shifted;
   logic [SAMPLE_W:0]          interp_mag;
   logic [SAMPLE_W-1:0]        abs_x;
   logic [1:0]                 phase;

   always_comb begin
      abs_x = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
      taps[0] = hist_ff[0];
      taps[1] = hist_ff[1];
      taps[2] = hist_ff[2];
      taps[3] = sample;
      phase = ctrl.step - 2'd1;
      acc = '0;
      for (int t = 0; t < 4; t++) begin
         acc = acc + ACC_W'(interp_weight(phase, 2'(t))) * ACC_W'(taps[t]);
      end
      // Dropping the low seven bits of a two's complement value floors it.
      shifted = acc[SAMPLE_W+7:7];
      interp_mag = shifted[SAMPLE_W] ? (SAMPLE_W+1)'(-shifted) : (SAMPLE_W+1)'(shifted);

      peak_in = peak_ff;
      tpeak_in = tpeak_ff;
      sum_in = sum_ff;
      if (ctrl.clear) begin
         peak_in = '0;
         tpeak_in = '0;
         sum_in = '0;
      end else if (ctrl.active) begin
         if (ctrl.step == 2'd0) begin
            if (abs_x > peak_ff) peak_in = abs_x;
            if (abs_x > tpeak_ff) tpeak_in = abs_x;
         end else begin
            if (ctrl.fill_full && interp_mag > {1'b0, tpeak_ff}) begin
               tpeak_in = interp_mag[SAMPLE_W-1:0];
            end
            if (ctrl.step == 2'd1 && ctrl.count_it) begin
               sum_in = sum_ff + SUM_BITS'(prod_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         tpeak_ff <= '0;
         sum_ff <= '0;
         for (int i = 0; i < 3; i++) hist_ff[i] <= '0;
      end else begin
         peak_ff <= peak_in;
         tpeak_ff <= tpeak_in;
         sum_ff <= sum_in;
         if (ctrl.active && ctrl.step == 2'd3) begin
            hist_ff[0] <= hist_ff[1];
            hist_ff[1] <= hist_ff[2];
            hist_ff[2] <= sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= (2*SAMPLE_W)'(sample * sample);
   end

   assign peak = peak_ff;
   assign true_peak = tpeak_ff;
   assign square_sum = sum_ff;
endmodule
`default_nettype wire

/* rtl/core/spm_root.sv */
// Bit-serial mean (restoring divide) followed by digit-by-digit square root.
`default_nettype none
module spm_root #(
   parameter int FRAME_BITS = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [spm_pkg::SUM_BITS-1:0] numer,
   input  logic [FRAME_BITS-1:0]        denom,
   output logic                         done,
   output logic [spm_pkg::SAMPLE_W-1:0] root
);
   import spm_pkg::*;

   localparam int RW = SUM_BITS + 1;

   root_state_type      state_ff, state_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [FRAME_BITS-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [SUM_BITS-1:0] quo_ff, quo_in;
   logic [RW-1:0]       rt_ff, rt_in, bit_ff, bit_in;
   logic [FRAME_BITS:0] trial;
   logic                ge;
   logic [RW-1:0]       cand;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ROOT_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      rt_ff <= rt_in;
      bit_ff <= bit_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      rt_in = rt_ff;
      bit_in = bit_ff;
      trial = {rem_ff, quo_ff[SUM_BITS-1]};
      ge = trial >= {1'b0, den_ff};
      cand = rt_ff + bit_ff;
      if (start) begin
         state_in = ROOT_DIV;
         cnt_in = '0;
         rem_in = '0;
         den_in = denom;
         quo_in = numer;
      end else begin
         case (state_ff)
            ROOT_DIV: begin
               // The numerator shifts out at the top while quotient bits enter below.
               rem_in = ge ? FRAME_BITS'(trial - {1'b0, den_ff}) : FRAME_BITS'(trial);
               quo_in = {quo_ff[SUM_BITS-2:0], ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'(SUM_BITS - 1)) begin
                  state_in = ROOT_SQRT;
                  cnt_in = '0;
                  rt_in = '0;
                  bit_in = RW'(1) << (SUM_BITS - 1);
               end
            end
            ROOT_SQRT: begin
               if ({1'b0, quo_ff} >= cand) begin
                  quo_in = SUM_BITS'({1'b0, quo_ff} - cand);
                  rt_in = (rt_ff >> 1) + bit_ff;
               end else begin
                  rt_in = rt_ff >> 1;
               end
               bit_in = bit_ff >> 2;
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd31) state_in = ROOT_DONE;
            end
            ROOT_IDLE, ROOT_DONE: begin
            end
            default: state_in = ROOT_IDLE;
         endcase
      end
   end

   assign done = (state_ff == ROOT_DONE);
   assign root = rt_ff[SAMPLE_W-1:0];
endmodule
`default_nettype wire
